// ----- src/ffop_pkg.sv -----
package ffop_pkg;

  localparam int unsigned DEF_MAX_ENTRIES = 64;
  localparam int unsigned WORD_W          = 32;
  localparam int unsigned IN_DATA_W       = 64;
  localparam int unsigned OUT_DATA_W      = 72;

  localparam logic       ACT_CLAIM   = 1'b0;
  localparam logic       ACT_RELEASE = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CL_RD,
    S_CL_CHK,
    S_CL_END,
    S_INS_RD,
    S_INS_WR,
    S_RL_RD,
    S_RL_CHK,
    S_DEL_RD,
    S_DEL_WR,
    S_DONE
  } state_t;

  // Results of the shared compare unit
  typedef struct packed {
    logic              fits;
    logic [WORD_W-1:0] ext_next;
    logic              end_ovf;
    logic [WORD_W-1:0] end_val;
    logic              after_new;
    logic              key_hit;
  } cmp_res_t;

endpackage

// ----- src/ffop_ram.sv -----
module ffop_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/ffop_slot_alloc.sv -----
module ffop_slot_alloc #(
  parameter int unsigned MAX_ENTRIES = ffop_pkg::DEF_MAX_ENTRIES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           set_en,
  input  logic [$clog2(MAX_ENTRIES)-1:0] set_slot,
  input  logic                           clr_en,
  input  logic [$clog2(MAX_ENTRIES)-1:0] clr_slot,
  output logic                           any_free,
  output logic [$clog2(MAX_ENTRIES)-1:0] free_slot
);

  localparam int unsigned SW = $clog2(MAX_ENTRIES);

  logic [MAX_ENTRIES-1:0] valid_r;
  logic [MAX_ENTRIES-1:0] valid_nxt;

  // Mark slots taken and freed
  always_comb begin
    valid_nxt = valid_r;
    if (set_en) begin
      valid_nxt[set_slot] = 1'b1;
    end
    if (clr_en) begin
      valid_nxt[clr_slot] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Pick the lowest free slot
  always_comb begin
    any_free  = 1'b0;
    free_slot = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        any_free  = 1'b1;
        free_slot = SW'(i);
      end
    end
  end

endmodule

// ----- src/ffop_cmp_unit.sv -----
module ffop_cmp_unit #(
  parameter int unsigned MAX_ENTRIES = ffop_pkg::DEF_MAX_ENTRIES
) (
  input  logic [ffop_pkg::WORD_W-1:0]    next_off,
  input  logic [ffop_pkg::WORD_W-1:0]    req_size,
  input  logic [ffop_pkg::WORD_W-1:0]    req_key,
  input  logic [$clog2(MAX_ENTRIES)-1:0] req_slot,
  input  logic [ffop_pkg::WORD_W-1:0]    rec_off,
  input  logic [ffop_pkg::WORD_W-1:0]    rec_size,
  input  logic [ffop_pkg::WORD_W-1:0]    rec_key,
  input  logic [$clog2(MAX_ENTRIES)-1:0] rec_slot,
  output ffop_pkg::cmp_res_t             res
);

  localparam int unsigned W = ffop_pkg::WORD_W;

  logic [W:0]   req_end;
  logic [W-1:0] rec_end;

  assign req_end = {1'b0, next_off} + {1'b0, req_size};
  assign rec_end = rec_off + rec_size;

  // Gap test, forward-only candidate, ordering and key match
  always_comb begin
    res.fits      = req_end <= {1'b0, rec_off};
    res.ext_next  = (rec_end > next_off) ? rec_end : next_off;
    res.end_ovf   = req_end[W];
    res.end_val   = req_end[W-1:0];
    res.after_new = (rec_off > next_off) || ((rec_off == next_off) && (rec_slot > req_slot));
    res.key_hit   = rec_key == req_key;
  end

endmodule

// ----- src/first_fit_offset_planner_unit.sv -----
// First-fit offset planner.
// Input channel in_*: in_tuser is the action (0 claim, 1 release), in_tdata
// carries tensor_key and claim_size. Each request gives exactly one result on
// out_*: region_offset, peak_capacity and status (ok, key not found, table
// full, end overflow). Live regions sit in a RAM kept sorted by base offset
// (then slot), walked one entry at a time by a single compare unit.
// A claim walks the regions in order to find its gap, then shifts the
// regions after it up by one; a release walks to its key and closes the
// hole by moving the later regions down. A claim on a full table skips
// the walk and goes straight to its result. Requests do not overlap: the
// next is taken only once the last result is in the output register.
// in_tready is high only while the sequencer is idle. A finished result sits
// in an output register; while the receiver stalls it holds, and the
// sequencer waits with its next result until the register empties.
// Synchronous active-low reset empties the table, clears peak capacity and
// drops any pending result; the RAM contents are not cleared.
module first_fit_offset_planner_unit #(
  parameter int unsigned MAX_ENTRIES = ffop_pkg::DEF_MAX_ENTRIES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ffop_pkg::IN_DATA_W-1:0]  in_tdata,   // [31:0] tensor_key, [63:32] claim_size
  input  logic                            in_tuser,   // [0] action
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ffop_pkg::OUT_DATA_W-1:0] out_tdata   // [31:0] region_offset,
                                                       // [63:32] peak_capacity,
                                                       // [65:64] status
);

  localparam int unsigned W  = ffop_pkg::WORD_W;
  localparam int unsigned SW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned RW = 3 * W + SW;

  ffop_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] p_r, p_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [W-1:0]  next_r, next_nxt;
  logic [W-1:0]  key_r, key_nxt;
  logic [W-1:0]  size_r, size_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic [W-1:0]  off_r, off_nxt;
  logic [1:0]    st_r, st_nxt;
  logic [W-1:0]  cap_r, cap_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [ffop_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic          ram_we;
  logic [SW-1:0] ram_waddr;
  logic [RW-1:0] ram_wdata;
  logic [SW-1:0] ram_raddr;
  logic [RW-1:0] ram_rdata;
  logic [RW-1:0] new_rec;

  logic          set_en, clr_en;
  logic          any_free;
  logic [SW-1:0] free_slot;

  logic          out_free;
  logic [CW-1:0] p_inc, p_dec;

  ffop_pkg::cmp_res_t cres;

  ffop_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ffop_slot_alloc #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_slots (
    .clk       (clk),
    .rst_n     (rst_n),
    .set_en    (set_en),
    .set_slot  (slot_r),
    .clr_en    (clr_en),
    .clr_slot  (ram_rdata[3*W +: SW]),
    .any_free  (any_free),
    .free_slot (free_slot)
  );

  ffop_cmp_unit #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_cmp (
    .next_off (next_r),
    .req_size (size_r),
    .req_key  (key_r),
    .req_slot (slot_r),
    .rec_off  (ram_rdata[0 +: W]),
    .rec_size (ram_rdata[W +: W]),
    .rec_key  (ram_rdata[2*W +: W]),
    .rec_slot (ram_rdata[3*W +: SW]),
    .res      (cres)
  );

  assign new_rec   = {slot_r, key_r, size_r, next_r};
  assign out_free  = !out_valid_r || out_tready;
  assign p_inc     = p_r + CW'(1);
  assign p_dec     = p_r - CW'(1);
  assign in_tready = (state_r == ffop_pkg::S_IDLE);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ffop_pkg::S_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == ffop_pkg::ACT_RELEASE) begin
            state_nxt = ffop_pkg::S_RL_RD;
          end else if (!any_free) begin
            state_nxt = ffop_pkg::S_DONE;
          end else begin
            state_nxt = ffop_pkg::S_CL_RD;
          end
        end
      end
      ffop_pkg::S_CL_RD:  state_nxt = (p_r == n_r) ? ffop_pkg::S_CL_END : ffop_pkg::S_CL_CHK;
      ffop_pkg::S_CL_CHK: state_nxt = cres.fits ? ffop_pkg::S_CL_END : ffop_pkg::S_CL_RD;
      ffop_pkg::S_CL_END: state_nxt = cres.end_ovf ? ffop_pkg::S_DONE : ffop_pkg::S_INS_RD;
      ffop_pkg::S_INS_RD: state_nxt = (p_r == '0) ? ffop_pkg::S_DONE : ffop_pkg::S_INS_WR;
      ffop_pkg::S_INS_WR: state_nxt = cres.after_new ? ffop_pkg::S_INS_RD : ffop_pkg::S_DONE;
      ffop_pkg::S_RL_RD:  state_nxt = (p_r == n_r) ? ffop_pkg::S_DONE : ffop_pkg::S_RL_CHK;
      ffop_pkg::S_RL_CHK: state_nxt = cres.key_hit ? ffop_pkg::S_DEL_RD : ffop_pkg::S_RL_RD;
      ffop_pkg::S_DEL_RD: state_nxt = (p_inc == n_r) ? ffop_pkg::S_DONE : ffop_pkg::S_DEL_WR;
      ffop_pkg::S_DEL_WR: state_nxt = ffop_pkg::S_DEL_RD;
      ffop_pkg::S_DONE:   state_nxt = out_free ? ffop_pkg::S_IDLE : ffop_pkg::S_DONE;
      default:            state_nxt = ffop_pkg::S_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    p_nxt         = p_r;
    n_nxt         = n_r;
    next_nxt      = next_r;
    key_nxt       = key_r;
    size_nxt      = size_r;
    slot_nxt      = slot_r;
    off_nxt       = off_r;
    st_nxt        = st_r;
    cap_nxt       = cap_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = p_r[SW-1:0];
    ram_wdata     = ram_rdata;
    ram_raddr     = p_r[SW-1:0];
    set_en        = 1'b0;
    clr_en        = 1'b0;
    case (state_r)
      // Latch the request and start the walk
      ffop_pkg::S_IDLE: begin
        if (in_tvalid) begin
          key_nxt  = in_tdata[0 +: W];
          size_nxt = in_tdata[W +: W];
          slot_nxt = free_slot;
          next_nxt = '0;
          off_nxt  = '0;
          p_nxt    = '0;
          st_nxt   = (in_tuser == ffop_pkg::ACT_CLAIM && !any_free) ?
                     ffop_pkg::ST_FULL : ffop_pkg::ST_OK;
        end
      end
      // Advance the candidate base past regions that block it
      ffop_pkg::S_CL_CHK: begin
        if (!cres.fits) begin
          next_nxt = cres.ext_next;
          p_nxt    = p_inc;
        end
      end
      ffop_pkg::S_CL_END: begin
        p_nxt = n_r;
        if (cres.end_ovf) begin
          st_nxt = ffop_pkg::ST_OVERFLOW;
        end
      end
      ffop_pkg::S_INS_RD: begin
        ram_raddr = p_dec[SW-1:0];
        if (p_r == '0) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = new_rec;
        end
      end
      // Shift later regions up, then drop in the new one
      ffop_pkg::S_INS_WR: begin
        ram_we = 1'b1;
        if (cres.after_new) begin
          ram_wdata = ram_rdata;
          p_nxt     = p_dec;
        end else begin
          ram_wdata = new_rec;
        end
      end
      ffop_pkg::S_RL_RD: begin
        if (p_r == n_r) begin
          st_nxt = ffop_pkg::ST_NOT_FOUND;
        end
      end
      ffop_pkg::S_RL_CHK: begin
        if (cres.key_hit) begin
          off_nxt = ram_rdata[0 +: W];
          clr_en  = 1'b1;
        end else begin
          p_nxt = p_inc;
        end
      end
      // Close the hole left by the released region
      ffop_pkg::S_DEL_RD: begin
        ram_raddr = p_inc[SW-1:0];
        if (p_inc == n_r) begin
          n_nxt = n_r - CW'(1);
        end
      end
      ffop_pkg::S_DEL_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        p_nxt     = p_inc;
      end
      ffop_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'b0, st_r, cap_r, off_r};
        end
      end
      default: begin
      end
    endcase
    // Commit a placed claim
    if ((state_r == ffop_pkg::S_INS_RD && p_r == '0) ||
        (state_r == ffop_pkg::S_INS_WR && !cres.after_new)) begin
      set_en  = 1'b1;
      n_nxt   = n_r + CW'(1);
      off_nxt = next_r;
      if (cap_r < cres.end_val) begin
        cap_nxt = cres.end_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffop_pkg::S_IDLE;
      n_r         <= '0;
      cap_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r        <= p_nxt;
    next_r     <= next_nxt;
    key_r      <= key_nxt;
    size_r     <= size_nxt;
    slot_r     <= slot_nxt;
    off_r      <= off_nxt;
    st_r       <= st_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CW'(MAX_ENTRIES))
    else $error("region count exceeds table size");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("sequencer idle right after a request");

  a_done_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ffop_pkg::S_DONE && out_free |=> out_tvalid)
    else $error("finished result not presented");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ffop_pkg::S_DONE && st_r == ffop_pkg::ST_FULL |-> n_r == CW'(MAX_ENTRIES))
    else $error("table full reported with free slots");
`endif

endmodule

// ----- tb/first_fit_offset_planner_unit_tb.sv -----
`timescale 1ns / 1ps

module first_fit_offset_planner_unit_tb;

  localparam int unsigned SLOTS = ffop_pkg::DEF_MAX_ENTRIES;
  localparam int unsigned N_RANDOM = 1750;

  typedef struct {
    logic [31:0] region_offset;
    logic [31:0] peak_capacity;
    logic [1:0]  status;
  } alloc_result_t;

  typedef struct {
    logic        action;
    logic [31:0] tensor_key;
    logic [31:0] claim_size;
    bit          typed;
    logic [31:0] region_offset;
    logic [31:0] peak_capacity;
    logic [1:0]  status;
  } plan_row_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [ffop_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                            in_tuser = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [ffop_pkg::OUT_DATA_W-1:0] out_tdata;

  // Region table as the planner should hold it
  bit          live_valid [SLOTS];
  logic [31:0] live_offset[SLOTS];
  logic [31:0] live_size  [SLOTS];
  logic [31:0] live_key   [SLOTS];
  logic [31:0] peak_seen;

  alloc_result_t pending_results[$];
  int unsigned   mismatches = 0;
  int unsigned   tx_idle_pct = 0;
  int unsigned   rx_idle_pct = 0;
  bit            hold_off_req = 1'b0;

  first_fit_offset_planner_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #4 clk = ~clk;

  initial begin
    #40ms;
    $display("FAIL");
    $finish;
  end

  // Walk order: by offset, then by slot number
  function automatic bit walks_first(int a, int b);
    if (live_offset[a] != live_offset[b]) return live_offset[a] < live_offset[b];
    return a < b;
  endfunction

  function automatic int walk_after(int prev);
    int best;
    best = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (!live_valid[i]) continue;
      if (prev >= 0 && !walks_first(prev, i)) continue;
      if (best < 0 || walks_first(i, best)) best = i;
    end
    return best;
  endfunction

  // Apply one request to the region table and return its result
  function automatic alloc_result_t plan_request(logic act, logic [31:0] key,
                                                 logic [31:0] size);
    alloc_result_t r;
    int slot;
    int i;
    logic [32:0] cand;
    logic [32:0] rend;
    logic [32:0] fin;
    slot = -1;
    cand = '0;
    r.region_offset = '0;
    r.status = ffop_pkg::ST_OK;
    if (act == ffop_pkg::ACT_CLAIM) begin
      for (int s = 0; s < SLOTS; s++)
        if (!live_valid[s] && slot < 0) slot = s;
      if (slot < 0) begin
        r.status = ffop_pkg::ST_FULL;
      end else begin
        i = walk_after(-1);
        while (i >= 0) begin
          rend = {1'b0, live_offset[i]} + {1'b0, live_size[i]};
          if (cand + {1'b0, size} <= {1'b0, live_offset[i]}) break;
          if (rend > cand) cand = rend;
          i = walk_after(i);
        end
        fin = cand + {1'b0, size};
        if (fin[32]) begin
          r.status = ffop_pkg::ST_OVERFLOW;
        end else begin
          live_valid[slot] = 1'b1;
          live_offset[slot] = cand[31:0];
          live_size[slot] = size;
          live_key[slot] = key;
          if (peak_seen < fin[31:0]) peak_seen = fin[31:0];
          r.region_offset = cand[31:0];
        end
      end
    end else begin
      r.status = ffop_pkg::ST_NOT_FOUND;
      i = walk_after(-1);
      while (i >= 0) begin
        if (live_key[i] == key) begin
          live_valid[i] = 1'b0;
          r.region_offset = live_offset[i];
          r.status = ffop_pkg::ST_OK;
          break;
        end
        i = walk_after(i);
      end
    end
    r.peak_capacity = peak_seen;
    return r;
  endfunction

  // Offer one request, predict on acceptance
  task automatic send_request(plan_row_t row);
    alloc_result_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= row.action;
    in_tdata  <= {row.claim_size, row.tensor_key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = plan_request(row.action, row.tensor_key, row.claim_size);
    if (row.typed) begin
      r.region_offset = row.region_offset;
      r.peak_capacity = row.peak_capacity;
      r.status = row.status;
    end
    pending_results.push_back(r);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Check each accepted result against the oldest prediction
  always @(posedge clk) begin
    alloc_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result %h", out_tdata);
        mismatches++;
      end else begin
        e = pending_results.pop_front();
        if (out_tdata[31:0] !== e.region_offset) begin
          $error("region_offset expected %h got %h", e.region_offset, out_tdata[31:0]);
          mismatches++;
        end
        if (out_tdata[63:32] !== e.peak_capacity) begin
          $error("peak_capacity expected %h got %h", e.peak_capacity, out_tdata[63:32]);
          mismatches++;
        end
        if (out_tdata[65:64] !== e.status) begin
          $error("status expected %0d got %0d", e.status, out_tdata[65:64]);
          mismatches++;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic logic [31:0] pick_size();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 70) return $urandom_range(255);
    if (k < 80) return 32'd0;
    if (k < 90) return $urandom;
    return 32'd1 << $urandom_range(31);
  endfunction

  function automatic logic [31:0] pick_key(logic act);
    int unsigned k;
    int s;
    k = $urandom_range(99);
    if (act == ffop_pkg::ACT_RELEASE && k < 80) begin
      s = $urandom_range(SLOTS - 1);
      for (int n = 0; n < SLOTS; n++)
        if (live_valid[(s + n) % SLOTS]) return live_key[(s + n) % SLOTS];
    end
    if (k < 90 && k >= 10) return $urandom_range(15);
    return $urandom;
  endfunction

  initial begin
    plan_row_t directed[$];
    plan_row_t row;
    int unsigned fill_bias;

    for (int s = 0; s < SLOTS; s++) begin
      live_valid[s] = 1'b0;
      live_offset[s] = '0;
      live_size[s] = '0;
      live_key[s] = '0;
    end
    peak_seen = '0;

    // Release on an empty table, zero-size claim, gap reuse, duplicate keys,
    // end overflow, extremes of key and size
    directed.push_back('{ffop_pkg::ACT_RELEASE, 32'd5, 32'd0, 1, 32'd0, 32'd0,
                         ffop_pkg::ST_NOT_FOUND});
    directed.push_back('{ffop_pkg::ACT_CLAIM, 32'd0, 32'd0, 1, 32'd0, 32'd0,
                         ffop_pkg::ST_OK});
    directed.push_back('{ffop_pkg::ACT_CLAIM, 32'd1, 32'd16, 1, 32'd0, 32'd16,
                         ffop_pkg::ST_OK});
    directed.push_back('{ffop_pkg::ACT_CLAIM, 32'd2, 32'd8, 0, '0, '0, ffop_pkg::ST_OK});
    directed.push_back('{ffop_pkg::ACT_RELEASE, 32'd1, 32'hFFFF_FFFF, 0, '0, '0,
                         ffop_pkg::ST_OK});
    directed.push_back('{ffop_pkg::ACT_CLAIM, 32'd3, 32'd4, 0, '0, '0, ffop_pkg::ST_OK});
    directed.push_back('{ffop_pkg::ACT_CLAIM, 32'd3, 32'd12, 0, '0, '0, ffop_pkg::ST_OK});
    directed.push_back('{ffop_pkg::ACT_RELEASE, 32'd3, 32'd0, 0, '0, '0, ffop_pkg::ST_OK});
    directed.push_back('{ffop_pkg::ACT_CLAIM, 32'd7, 32'd0, 0, '0, '0, ffop_pkg::ST_OK});
    directed.push_back('{ffop_pkg::ACT_CLAIM, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 0, '0, '0,
                         ffop_pkg::ST_OK});
    directed.push_back('{ffop_pkg::ACT_CLAIM, 32'hAAAA_AAAA, 32'h5555_5555, 0, '0, '0,
                         ffop_pkg::ST_OK});
    directed.push_back('{ffop_pkg::ACT_CLAIM, 32'h5555_5555, 32'hAAAA_AAAA, 0, '0, '0,
                         ffop_pkg::ST_OK});
    directed.push_back('{ffop_pkg::ACT_RELEASE, 32'hFFFF_FFFF, 32'd0, 0, '0, '0,
                         ffop_pkg::ST_OK});
    directed.push_back('{ffop_pkg::ACT_RELEASE, 32'hAAAA_AAAA, 32'd0, 0, '0, '0,
                         ffop_pkg::ST_OK});
    directed.push_back('{ffop_pkg::ACT_RELEASE, 32'd2, 32'd0, 0, '0, '0, ffop_pkg::ST_OK});
    directed.push_back('{ffop_pkg::ACT_RELEASE, 32'd0, 32'd0, 0, '0, '0, ffop_pkg::ST_OK});
    directed.push_back('{ffop_pkg::ACT_RELEASE, 32'd7, 32'd0, 0, '0, '0, ffop_pkg::ST_OK});
    directed.push_back('{ffop_pkg::ACT_RELEASE, 32'h5555_5555, 32'd0, 0, '0, '0,
                         ffop_pkg::ST_OK});
    directed.push_back('{ffop_pkg::ACT_CLAIM, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, '0, '0,
                         ffop_pkg::ST_OK});
    directed.push_back('{ffop_pkg::ACT_CLAIM, 32'd9, 32'd1, 0, '0, '0, ffop_pkg::ST_OK});
    directed.push_back('{ffop_pkg::ACT_RELEASE, 32'hFFFF_FFFF, 32'd0, 0, '0, '0,
                         ffop_pkg::ST_OK});

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 15;
    rx_idle_pct = 66;
    foreach (directed[i]) send_request(directed[i]);
    drain_results();

    // Alternate fill and drain bursts so the table reaches full and empty
    fill_bias = 85;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 3) begin
        drain_results();
        tx_idle_pct = 66;
        rx_idle_pct = 15;
      end
      if (n == 2 * N_RANDOM / 3) begin
        drain_results();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_off_req = 1'b1;
      end
      if (n % 150 == 0) fill_bias = (fill_bias == 85) ? 15 : 85;
      row.action = ($urandom_range(99) < fill_bias) ? ffop_pkg::ACT_CLAIM :
                                                      ffop_pkg::ACT_RELEASE;
      row.tensor_key = pick_key(row.action);
      row.claim_size = (row.action == ffop_pkg::ACT_CLAIM) ? pick_size() : $urandom;
      row.typed = 1'b0;
      row.region_offset = '0;
      row.peak_capacity = '0;
      row.status = ffop_pkg::ST_OK;
      send_request(row);
    end
    drain_results();
    repeat (300) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
